@@ hw/rtl/mes_pkg.sv @@
// Shared types and opcode constants for the MIPS execute stage with forwarding.
`timescale 1ns / 1ps
package mes_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned RegW  = 5;
  localparam int unsigned OpW   = 6;
  localparam int unsigned CtlW  = 4;

  localparam logic [RegW-1:0] LinkReg  = 5'd31;
  localparam int unsigned     LuiShift = 16;

  // R-type funct codes
  localparam logic [OpW-1:0] FnSll  = 6'h00;
  localparam logic [OpW-1:0] FnSrl  = 6'h02;
  localparam logic [OpW-1:0] FnAdd  = 6'h20;
  localparam logic [OpW-1:0] FnAddu = 6'h21;
  localparam logic [OpW-1:0] FnSub  = 6'h22;
  localparam logic [OpW-1:0] FnSubu = 6'h23;
  localparam logic [OpW-1:0] FnAnd  = 6'h24;
  localparam logic [OpW-1:0] FnOr   = 6'h25;
  localparam logic [OpW-1:0] FnNor  = 6'h27;
  localparam logic [OpW-1:0] FnSlt  = 6'h2A;
  localparam logic [OpW-1:0] FnSltu = 6'h2B;

  // Major opcodes
  localparam logic [OpW-1:0] OpRtype = 6'h00;
  localparam logic [OpW-1:0] OpBeq   = 6'h04;
  localparam logic [OpW-1:0] OpBne   = 6'h05;
  localparam logic [OpW-1:0] OpAddi  = 6'h08;
  localparam logic [OpW-1:0] OpAddiu = 6'h09;
  localparam logic [OpW-1:0] OpSlti  = 6'h0A;
  localparam logic [OpW-1:0] OpSltiu = 6'h0B;
  localparam logic [OpW-1:0] OpAndi  = 6'h0C;
  localparam logic [OpW-1:0] OpOri   = 6'h0D;
  localparam logic [OpW-1:0] OpLui   = 6'h0F;
  localparam logic [OpW-1:0] OpLw    = 6'h23;
  localparam logic [OpW-1:0] OpSw    = 6'h2B;

  // Control bit positions
  localparam int unsigned CtlRegDst   = 0;
  localparam int unsigned CtlJal      = 1;
  localparam int unsigned CtlRegWrite = 2;
  localparam int unsigned CtlMemToReg = 3;

  typedef struct packed {
    logic [RegW-1:0]  src_a_index;
    logic [RegW-1:0]  src_b_index;
    logic [RegW-1:0]  dest_index;
    logic [OpW-1:0]   major_op;
    logic [OpW-1:0]   minor_op;
    logic [RegW-1:0]  shift_amount;
    logic [DataW-1:0] immediate;
    logic [DataW-1:0] next_pc;
    logic [DataW-1:0] rs_value;
    logic [DataW-1:0] rt_value;
    logic [CtlW-1:0]  control_bits;
    logic [DataW-1:0] load_data;
  } instr_t;

  typedef struct packed {
    logic [DataW-1:0] alu_value;
    logic [DataW-1:0] store_value;
    logic [DataW-1:0] branch_target;
    logic             branch_condition;
    logic [RegW-1:0]  write_index;
    logic [CtlW-1:0]  control_out;
  } result_t;

endpackage

@@ hw/rtl/mes_channels.sv @@
// Valid/ready channel interfaces for instructions in and results out.
`timescale 1ns / 1ps
interface mes_instr_if;
  import mes_pkg::*;
  logic   valid;
  logic   ready;
  instr_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface mes_result_if;
  import mes_pkg::*;
  logic    valid;
  logic    ready;
  result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ hw/rtl/mips_execute_stage_forwarding.sv @@
// Top level of the MIPS execute stage with two-deep operand forwarding.
//
//   channel   | dir | handshake     | payload
//   ----------+-----+---------------+---------------------------------
//   instr_i   | in  | valid / ready | decoded instruction, mes_pkg::instr_t
//   result_o  | out | valid / ready | ALU result and write-back info, result_t
//
// One instruction per cycle sustained while result_o is ready; an instruction
// passes through the input register, then the result register, before it
// can transfer out.
// Operand forwarding, ALU and branch compare sit between the two registers.
// Reset clears the valid flags and the forwarding history to zero.
// A stalled result holds the result register; the input register keeps
// accepting until it too holds an instruction.
`timescale 1ns / 1ps
module mips_execute_stage_forwarding (
  input logic         clk_i,
  input logic         rst_ni,
  mes_instr_if.sink   instr_i,
  mes_result_if.source result_o
);
  import mes_pkg::*;

  logic             in_valid_q;
  instr_t           in_q;
  logic             out_valid_q;
  result_t          out_q;
  result_t          res_d;
  logic             advance;

  logic [RegW-1:0]  near_dest_q, far_dest_q;
  logic             near_writes_q, far_writes_q;
  logic [DataW-1:0] near_value_q, far_value_q;
  logic             near_mem_q, far_mem_q;

  logic [DataW-1:0] op_a, op_b, alu, store;
  logic             cond;
  logic [RegW-1:0]  widx;

  function automatic logic [DataW-1:0] pick(
    input logic [RegW-1:0]  idx,
    input logic [DataW-1:0] regval,
    input logic [DataW-1:0] load,
    input logic [RegW-1:0]  near_dest,
    input logic             near_writes,
    input logic [DataW-1:0] near_value,
    input logic [RegW-1:0]  far_dest,
    input logic             far_writes,
    input logic [DataW-1:0] far_value,
    input logic             far_mem
  );
    logic [DataW-1:0] r;
    r = regval;
    if (idx != '0 && far_writes && far_dest == idx && far_dest != near_dest) begin
      r = far_mem ? load : far_value;
    end else if (idx != '0 && near_writes && near_dest == idx) begin
      r = near_value;
    end
    return r;
  endfunction

  // Move the held instruction into the result register when it is free
  assign advance       = in_valid_q && (!out_valid_q || result_o.ready);
  assign instr_i.ready = !in_valid_q || advance;

  // Select forwarded operands
  always_comb begin
    op_a = pick(in_q.src_a_index, in_q.rs_value, in_q.load_data,
                near_dest_q, near_writes_q, near_value_q,
                far_dest_q, far_writes_q, far_value_q, far_mem_q);
    op_b = pick(in_q.src_b_index, in_q.rt_value, in_q.load_data,
                near_dest_q, near_writes_q, near_value_q,
                far_dest_q, far_writes_q, far_value_q, far_mem_q);
  end

  // Decode and compute the ALU result and branch condition
  always_comb begin
    alu  = '0;
    cond = 1'b0;
    if (in_q.major_op == OpRtype) begin
      unique case (in_q.minor_op)
        FnAdd, FnAddu: alu = op_a + op_b;
        FnSub, FnSubu: alu = op_a - op_b;
        FnAnd:         alu = op_a & op_b;
        FnOr:          alu = op_a | op_b;
        FnNor:         alu = ~(op_a | op_b);
        FnSlt:         alu = {{(DataW-1){1'b0}}, $signed(op_a) < $signed(op_b)};
        FnSltu:        alu = {{(DataW-1){1'b0}}, op_a < op_b};
        FnSll:         alu = op_b << in_q.shift_amount;
        FnSrl:         alu = op_b >> in_q.shift_amount;
        default:       alu = '0;
      endcase
    end else begin
      unique case (in_q.major_op)
        OpAddi, OpAddiu, OpLw, OpSw: alu = op_a + in_q.immediate;
        OpAndi:  alu = op_a & in_q.immediate;
        OpOri:   alu = op_a | in_q.immediate;
        OpLui:   alu = in_q.immediate << LuiShift;
        OpSlti:  alu = {{(DataW-1){1'b0}}, $signed(op_a) < $signed(in_q.immediate)};
        OpSltiu: alu = {{(DataW-1){1'b0}}, op_a < in_q.immediate};
        OpBeq:   cond = (op_a == op_b);
        OpBne:   cond = (op_a != op_b);
        default: alu = '0;
      endcase
    end
  end

  // Form store data, destination and the full result
  always_comb begin
    store = in_q.control_bits[CtlJal] ? (in_q.next_pc + DataW'(4)) : op_b;
    if (in_q.control_bits[CtlRegDst]) begin
      widx = in_q.dest_index;
    end else if (in_q.control_bits[CtlJal]) begin
      widx = LinkReg;
    end else begin
      widx = in_q.src_b_index;
    end
    res_d.alu_value        = alu;
    res_d.store_value      = store;
    res_d.branch_target    = in_q.next_pc + {in_q.immediate[DataW-3:0], 2'b00};
    res_d.branch_condition = cond;
    res_d.write_index      = widx;
    res_d.control_out      = in_q.control_bits;
  end

  // Capture an incoming instruction on transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (instr_i.ready) begin
      in_valid_q <= instr_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (instr_i.valid && instr_i.ready) begin
      in_q <= instr_i.payload;
    end
  end

  // Hold or advance the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res_d;
    end
  end

  // Shift the forwarding history as each instruction completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_dest_q   <= '0;
      near_writes_q <= 1'b0;
      near_value_q  <= '0;
      near_mem_q    <= 1'b0;
      far_dest_q    <= '0;
      far_writes_q  <= 1'b0;
      far_value_q   <= '0;
      far_mem_q     <= 1'b0;
    end else if (advance) begin
      far_dest_q    <= near_dest_q;
      far_writes_q  <= near_writes_q;
      far_value_q   <= near_value_q;
      far_mem_q     <= near_mem_q;
      near_dest_q   <= widx;
      near_writes_q <= in_q.control_bits[CtlRegWrite];
      near_value_q  <= alu;
      near_mem_q    <= in_q.control_bits[CtlMemToReg];
    end
  end

  assign result_o.valid   = out_valid_q;
  assign result_o.payload = out_q;

  // A full input register that cannot drain keeps its instruction
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !result_o.ready |=> in_valid_q)
    else $error("held instruction dropped");

  // A stalled result stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !result_o.ready |=> out_valid_q && $stable(out_q))
    else $error("stalled result changed");

  // A taken branch never carries an ALU value
  a_branch_alu: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.branch_condition |-> out_q.alu_value == '0)
    else $error("branch result with nonzero ALU value");

  // A jal without regdst links to the return register
  a_jal_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.control_out[CtlJal] && !out_q.control_out[CtlRegDst]
      |-> out_q.write_index == LinkReg)
    else $error("jal destination is not the link register");

endmodule

@@ test/mes_forwarding_checker.sv @@
// Scoreboard for the execute stage: predicts every result and compares it field by field.
`timescale 1ns / 1ps
module mes_forwarding_checker
  import mes_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  mes_instr_if  instr_i,
  mes_result_if result_i,
  output int    mismatch_count_o,
  output int    pending_count_o,
  output int    checked_count_o,
  output int    forward_count_o
);

  // Forwarding history: near is one instruction back, far is two back
  logic [RegW-1:0]  near_wr_reg  = '0;
  logic             near_wr_en   = 1'b0;
  logic [DataW-1:0] near_alu     = '0;
  logic             near_is_load = 1'b0;
  logic [RegW-1:0]  far_wr_reg   = '0;
  logic             far_wr_en    = 1'b0;
  logic [DataW-1:0] far_alu      = '0;
  logic             far_is_load  = 1'b0;

  result_t expected_q[$];
  int      mismatches = 0;
  int      pending    = 0;
  int      checked    = 0;
  int      forwards   = 0;

  assign mismatch_count_o = mismatches;
  assign pending_count_o  = pending;
  assign checked_count_o  = checked;
  assign forward_count_o  = forwards;

  task automatic report_mismatch(input string what, input logic [DataW-1:0] got,
                                 input logic [DataW-1:0] want);
    $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  // Pick an operand: far wins only if near's destination is a different register
  function automatic logic [DataW-1:0] forward_operand(input logic [RegW-1:0]  idx,
                                                       input logic [DataW-1:0] reg_val,
                                                       input logic [DataW-1:0] mem_val);
    if (idx != '0 && far_wr_en && far_wr_reg == idx && far_wr_reg != near_wr_reg) begin
      forwards++;
      return far_is_load ? mem_val : far_alu;
    end
    if (idx != '0 && near_wr_en && near_wr_reg == idx) begin
      forwards++;
      return near_alu;
    end
    return reg_val;
  endfunction

  // Execute one instruction and advance the forwarding history
  function automatic result_t execute_instr(input instr_t ins);
    result_t          res;
    logic [DataW-1:0] op_a;
    logic [DataW-1:0] op_b;
    logic             link;

    link = ins.control_bits[CtlJal];
    op_a = forward_operand(ins.src_a_index, ins.rs_value, ins.load_data);
    op_b = forward_operand(ins.src_b_index, ins.rt_value, ins.load_data);

    res               = '0;
    res.store_value   = link ? ins.next_pc + 32'd4 : op_b;
    res.branch_target = ins.next_pc + (ins.immediate << 2);
    res.control_out   = ins.control_bits;

    if (ins.major_op == OpRtype) begin
      case (ins.minor_op)
        FnAdd, FnAddu: res.alu_value = op_a + op_b;
        FnSub, FnSubu: res.alu_value = op_a - op_b;
        FnAnd:         res.alu_value = op_a & op_b;
        FnOr:          res.alu_value = op_a | op_b;
        FnNor:         res.alu_value = ~(op_a | op_b);
        FnSlt:         res.alu_value = {{(DataW-1){1'b0}}, $signed(op_a) < $signed(op_b)};
        FnSltu:        res.alu_value = {{(DataW-1){1'b0}}, op_a < op_b};
        FnSll:         res.alu_value = op_b << ins.shift_amount;
        FnSrl:         res.alu_value = op_b >> ins.shift_amount;
        default:       res.alu_value = '0;
      endcase
    end else begin
      case (ins.major_op)
        OpAddi, OpAddiu, OpLw, OpSw: res.alu_value = op_a + ins.immediate;
        OpAndi:  res.alu_value = op_a & ins.immediate;
        OpOri:   res.alu_value = op_a | ins.immediate;
        OpLui:   res.alu_value = ins.immediate << LuiShift;
        OpSlti:  res.alu_value = {{(DataW-1){1'b0}}, $signed(op_a) < $signed(ins.immediate)};
        OpSltiu: res.alu_value = {{(DataW-1){1'b0}}, op_a < ins.immediate};
        OpBeq:   res.branch_condition = (op_a == op_b);
        OpBne:   res.branch_condition = (op_a != op_b);
        default: res.alu_value = '0;
      endcase
    end

    if (ins.control_bits[CtlRegDst]) begin
      res.write_index = ins.dest_index;
    end else if (link) begin
      res.write_index = LinkReg;
    end else begin
      res.write_index = ins.src_b_index;
    end

    // Shift history: near moves to far, this instruction becomes near
    far_wr_reg   = near_wr_reg;
    far_wr_en    = near_wr_en;
    far_alu      = near_alu;
    far_is_load  = near_is_load;
    near_wr_reg  = res.write_index;
    near_wr_en   = ins.control_bits[CtlRegWrite];
    near_alu     = res.alu_value;
    near_is_load = ins.control_bits[CtlMemToReg];
    return res;
  endfunction

  // Check result transfers first, then predict from instruction transfers
  always @(posedge clk_i) begin : watch
    result_t want;
    result_t got;
    if (rst_ni) begin
      if (result_i.valid && result_i.ready) begin
        got = result_i.payload;
        if (expected_q.size() == 0) begin
          report_mismatch("result with nothing outstanding", got.alu_value, '0);
        end else begin
          want = expected_q.pop_front();
          if (got.alu_value !== want.alu_value)
            report_mismatch("alu_value", got.alu_value, want.alu_value);
          if (got.store_value !== want.store_value)
            report_mismatch("store_value", got.store_value, want.store_value);
          if (got.branch_target !== want.branch_target)
            report_mismatch("branch_target", got.branch_target, want.branch_target);
          if (got.branch_condition !== want.branch_condition)
            report_mismatch("branch_condition", DataW'(got.branch_condition),
                            DataW'(want.branch_condition));
          if (got.write_index !== want.write_index)
            report_mismatch("write_index", DataW'(got.write_index),
                            DataW'(want.write_index));
          if (got.control_out !== want.control_out)
            report_mismatch("control_out", DataW'(got.control_out),
                            DataW'(want.control_out));
          checked++;
        end
      end
      if (instr_i.valid && instr_i.ready) begin
        expected_q.push_back(execute_instr(instr_i.payload));
      end
      pending = expected_q.size();
    end
  end

endmodule

@@ test/mips_execute_stage_forwarding_tb.sv @@
// Top of the execute stage testbench: clock, reset, instruction stimulus and verdict.
`timescale 1ns / 1ps
module mips_execute_stage_forwarding_tb;
  import mes_pkg::*;

  localparam int unsigned RandomItems = 525;
  localparam int unsigned SegmentLen  = 75;

  // Jump-and-link opcode; the stage itself only sees its control bits
  localparam logic [OpW-1:0] OpJal = 6'h03;

  // Typical control words
  localparam logic [CtlW-1:0] CtlNone   = '0;
  localparam logic [CtlW-1:0] CtlWrRt   = CtlW'(1) << CtlRegWrite;
  localparam logic [CtlW-1:0] CtlWrRd   = CtlWrRt | (CtlW'(1) << CtlRegDst);
  localparam logic [CtlW-1:0] CtlLoad   = CtlWrRt | (CtlW'(1) << CtlMemToReg);
  localparam logic [CtlW-1:0] CtlLink   = CtlWrRt | (CtlW'(1) << CtlJal);
  localparam logic [CtlW-1:0] CtlAllSet = '1;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic idle_en = 1'b1;
  int   sent    = 0;
  int   mismatches;
  int   pending;
  int   checked;
  int   forwards;

  mes_instr_if  instr_if ();
  mes_result_if result_if ();

  mips_execute_stage_forwarding dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .instr_i  (instr_if),
    .result_o (result_if)
  );

  mes_forwarding_checker u_scoreboard (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .instr_i          (instr_if),
    .result_i         (result_if),
    .mismatch_count_o (mismatches),
    .pending_count_o  (pending),
    .checked_count_o  (checked),
    .forward_count_o  (forwards)
  );

  always #5 clk_i = ~clk_i;

  // Operand values weighted toward the corners
  function automatic logic [DataW-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return DataW'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  // Register numbers mostly from a small pool so hazards are frequent
  function automatic logic [RegW-1:0] rand_reg();
    if ($urandom_range(0, 3) != 0) begin
      return RegW'($urandom_range(0, 3));
    end
    return RegW'($urandom);
  endfunction

  function automatic instr_t mk_instr(input logic [OpW-1:0] op, input logic [OpW-1:0] fn,
                                      input logic [RegW-1:0] rs, input logic [RegW-1:0] rt,
                                      input logic [RegW-1:0] rd, input logic [CtlW-1:0] ctl,
                                      input logic [DataW-1:0] rs_val,
                                      input logic [DataW-1:0] rt_val,
                                      input logic [DataW-1:0] imm);
    instr_t ins;
    ins.src_a_index  = rs;
    ins.src_b_index  = rt;
    ins.dest_index   = rd;
    ins.major_op     = op;
    ins.minor_op     = fn;
    ins.shift_amount = RegW'($urandom);
    ins.immediate    = imm;
    ins.next_pc      = $urandom;
    ins.rs_value     = rs_val;
    ins.rt_value     = rt_val;
    ins.control_bits = ctl;
    ins.load_data    = $urandom;
    return ins;
  endfunction

  // Mostly known operations with random operands, some fully random codes
  function automatic instr_t rand_instr();
    instr_t ins;
    ins = mk_instr(OpRtype, FnAdd, rand_reg(), rand_reg(), rand_reg(), CtlW'($urandom),
                   rand_word(), rand_word(), rand_word());
    if ($urandom_range(0, 4) != 0) ins.control_bits[CtlRegWrite] = 1'b1;
    if ($urandom_range(0, 9) == 0) begin
      ins.major_op = OpW'($urandom);
      ins.minor_op = OpW'($urandom);
    end else begin
      ins.minor_op = OpW'($urandom);
      case ($urandom_range(0, 21))
        0:  ins.minor_op = FnSll;
        1:  ins.minor_op = FnSrl;
        2:  ins.minor_op = FnAdd;
        3:  ins.minor_op = FnAddu;
        4:  ins.minor_op = FnSub;
        5:  ins.minor_op = FnSubu;
        6:  ins.minor_op = FnAnd;
        7:  ins.minor_op = FnOr;
        8:  ins.minor_op = FnNor;
        9:  ins.minor_op = FnSlt;
        10: ins.minor_op = FnSltu;
        11: ins.major_op = OpBeq;
        12: ins.major_op = OpBne;
        13: ins.major_op = OpAddi;
        14: ins.major_op = OpAddiu;
        15: ins.major_op = OpSlti;
        16: ins.major_op = OpSltiu;
        17: ins.major_op = OpAndi;
        18: ins.major_op = OpOri;
        19: ins.major_op = OpLui;
        20: ins.major_op = OpLw;
        default: ins.major_op = OpSw;
      endcase
    end
    return ins;
  endfunction

  // Drive one instruction after a random gap and hold it until the transfer
  task automatic send_instr(input instr_t ins);
    int gap;
    gap = idle_en ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      instr_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    instr_if.valid   <= 1'b1;
    instr_if.payload <= ins;
    @(posedge clk_i);
    while (!instr_if.ready) @(posedge clk_i);
    sent++;
  endtask

  // Drop valid and hold off until every outstanding result has arrived
  task automatic drain();
    instr_if.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Result side: random stalls per transfer, none while idling is off
  initial begin : result_sink
    int stall;
    result_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = idle_en ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      result_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!result_if.valid) @(posedge clk_i);
    end
  end

  initial begin : stimulus
    instr_t ins;
    rst_ni           <= 1'b0;
    instr_if.valid   <= 1'b0;
    instr_if.payload <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Forwarding chain: far ALU value, far load data, near value, near wins
    send_instr(mk_instr(OpAddiu, '0, 5'd0, 5'd1, 5'd0, CtlWrRt, 32'h5, '0, '1));
    send_instr(mk_instr(OpLw, '0, 5'd2, 5'd2, 5'd0, CtlLoad, 32'h100, '0, 32'h4));
    send_instr(mk_instr(OpRtype, FnAdd, 5'd1, 5'd0, 5'd3, CtlWrRd, '0, 32'h7, '0));
    send_instr(mk_instr(OpRtype, FnSub, 5'd2, 5'd3, 5'd4, CtlWrRd, '0, '0, '0));
    send_instr(mk_instr(OpRtype, FnAnd, 5'd3, 5'd4, 5'd3, CtlWrRd, '1, '1, '0));
    send_instr(mk_instr(OpRtype, FnOr, 5'd3, 5'd3, 5'd3, CtlWrRd, '0, '0, '0));
    send_instr(mk_instr(OpRtype, FnNor, 5'd3, 5'd3, 5'd5, CtlWrRd, '0, '0, '0));
    // Signed against unsigned compare, and a write to register zero
    send_instr(mk_instr(OpRtype, FnSlt, 5'd0, 5'd0, 5'd6, CtlWrRd, 32'h8000_0000, 32'h1, '0));
    send_instr(mk_instr(OpRtype, FnSltu, 5'd0, 5'd0, 5'd0, CtlWrRd, 32'h8000_0000, 32'h1, '0));
    // Shifts by the largest amount, 31; register zero is never forwarded
    ins = mk_instr(OpRtype, FnSll, 5'd0, 5'd0, 5'd7, CtlWrRd, '0, '1, '0);
    ins.shift_amount = '1;
    send_instr(ins);
    ins = mk_instr(OpRtype, FnSrl, 5'd0, 5'd7, 5'd8, CtlWrRd, '0, '1, '0);
    ins.shift_amount = '1;
    send_instr(ins);
    send_instr(mk_instr(OpRtype, '1, 5'd8, 5'd8, 5'd9, CtlWrRd, '1, '1, '0));
    // Branches, with a target that wraps
    ins = mk_instr(OpBeq, '0, 5'd8, 5'd8, 5'd0, CtlNone, '0, '0, '1);
    ins.next_pc = '1;
    send_instr(ins);
    send_instr(mk_instr(OpBne, '0, 5'd10, 5'd11, 5'd0, CtlNone, 32'h1234, 32'h1234, '0));
    send_instr(mk_instr(OpAddi, '0, 5'd31, 5'd12, 5'd0, CtlWrRt, '1, '0, 32'h7FFF_FFFF));
    send_instr(mk_instr(OpSlti, '0, 5'd13, 5'd13, 5'd0, CtlWrRt, '1, '0, '0));
    send_instr(mk_instr(OpSltiu, '0, 5'd13, 5'd14, 5'd0, CtlWrRt, '1, '0, '0));
    send_instr(mk_instr(OpAndi, '0, 5'd14, 5'd15, 5'd0, CtlWrRt, '1, '0, 32'h0000_FFFF));
    send_instr(mk_instr(OpOri, '0, 5'd15, 5'd16, 5'd0, CtlWrRt, '0, '0, 32'hFFFF_0000));
    send_instr(mk_instr(OpLui, '0, 5'd0, 5'd17, 5'd0, CtlWrRt, '0, '0, '1));
    send_instr(mk_instr(OpSw, '0, 5'd17, 5'd16, 5'd0, CtlNone, '0, '0, 32'h8000_0000));
    // Link: store gets next_pc + 4 (wrapping), link register forwards zero
    ins = mk_instr(OpJal, '0, 5'd0, 5'd0, 5'd0, CtlLink, '0, '0, '0);
    ins.next_pc = 32'hFFFF_FFFC;
    send_instr(ins);
    send_instr(mk_instr(OpRtype, FnAddu, 5'd31, 5'd31, 5'd18, CtlWrRd, '1, '1, '0));
    // Unknown opcode with every control bit set: rd beats the link register
    send_instr(mk_instr('1, '1, 5'd18, 5'd18, 5'd19, CtlAllSet, '1, '1, '1));
    send_instr(mk_instr(OpRtype, FnSubu, 5'd19, 5'd18, 5'd20, CtlWrRd, '0, '0, '0));

    // Let the pipeline run dry before the random part
    drain();

    for (int i = 0; i < RandomItems; i++) begin
      if (i % SegmentLen == 0) idle_en = ((i / SegmentLen) % 3) != 2;
      send_instr(rand_instr());
    end

    drain();
    repeat (10) @(posedge clk_i);

    $display("Ran %0d instructions (25 directed, %0d random) with random gaps and stalls;",
             sent, RandomItems);
    $display("checked %0d results, %0d operands came through forwarding.", checked, forwards);
    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog on a hung handshake
  initial begin : watchdog
    #2_000_000;
    $display("Timeout: %0d results still outstanding", pending);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ mips_execute_stage_forwarding.f @@
hw/rtl/mes_pkg.sv
hw/rtl/mes_channels.sv
hw/rtl/mips_execute_stage_forwarding.sv
test/mes_forwarding_checker.sv
test/mips_execute_stage_forwarding_tb.sv
